[src/whpp_pkg.sv]
`default_nettype none

package whpp_pkg;

   localparam int unsigned INDEX_BITS_DEFAULT  = 16;
   localparam int unsigned SAMPLE_BITS_DEFAULT = 32;

   // width of the offset register as it is written on the csr port
   localparam int unsigned CSR_BITS = 16;

   typedef enum logic [1:0] {
      STATUS_FOUND   = 2'd0,
      STATUS_NO_PEAK = 2'd1,
      STATUS_SHORT   = 2'd2
   } status_type;

endpackage

`default_nettype wire

[src/windowed_highest_peak_picker.sv]
// Highest local maximum of a window of samples. Samples of one window arrive in
// order on req, tlast on the final one. Position p (from 0) is a peak when it
// rises above p-1 and p+1 does not exceed it; the last three samples of a window
// never yield a peak. Each sample passes through a single register stage, so a
// word is accepted every cycle while the result side keeps up; only a tlast word
// waits when the result register is still full. On tlast one word leaves on
// rsp: the highest peak's position plus the csr offset (saturating), its value,
// and a status (found, no peak, or window shorter than 3 samples).
// The offset may only be written while the block is idle.
`default_nettype none

module windowed_highest_peak_picker #(
   parameter int unsigned INDEX_BITS  = whpp_pkg::INDEX_BITS_DEFAULT,
   parameter int unsigned SAMPLE_BITS = whpp_pkg::SAMPLE_BITS_DEFAULT,
   localparam int unsigned REQ_BITS   = ((SAMPLE_BITS + 7) / 8) * 8,
   localparam int unsigned RSP_USED   = INDEX_BITS + SAMPLE_BITS + 2,
   localparam int unsigned RSP_BITS   = ((RSP_USED + 7) / 8) * 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,

   input  wire logic                          req_tvalid,
   output      logic                          req_tready,
   input  wire logic [REQ_BITS-1:0]           req_tdata,  // sample
   input  wire logic                          req_tlast,  // last_sample

   output      logic                          rsp_tvalid,
   input  wire logic                          rsp_tready,
   output      logic [RSP_BITS-1:0]           rsp_tdata,  // peak_index, peak_value, status

   input  wire logic                          csr_valid,
   output      logic                          csr_ready,
   input  wire logic [whpp_pkg::CSR_BITS-1:0] csr_data    // index_offset
);

   localparam logic [INDEX_BITS-1:0] POS_MAX = {INDEX_BITS{1'b1}};

   logic [INDEX_BITS-1:0] offset_ff, offset_in;

   logic signed [SAMPLE_BITS-1:0] prev_ff, prev_in;
   logic                          rising_ff, rising_in;
   logic [INDEX_BITS-1:0]         pos_ff, pos_in;
   logic                          best_valid_ff, best_valid_in;
   logic signed [SAMPLE_BITS-1:0] best_value_ff, best_value_in;
   logic [INDEX_BITS-1:0]         best_pos_ff, best_pos_in;
   logic [1:0]                    pend_valid_ff, pend_valid_in;
   logic signed [SAMPLE_BITS-1:0] pend_value_ff [2];
   logic signed [SAMPLE_BITS-1:0] pend_value_in [2];
   logic [INDEX_BITS-1:0]         pend_pos_ff [2];
   logic [INDEX_BITS-1:0]         pend_pos_in [2];

   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic                           req_take;
   logic signed [SAMPLE_BITS-1:0]  sample;
   logic                           peak_here;
   logic                           confirm;
   logic [whpp_pkg::CSR_BITS+INDEX_BITS-1:0] csr_ext;
   logic [INDEX_BITS:0]            index_sum;
   logic [INDEX_BITS-1:0]          peak_index;
   logic signed [SAMPLE_BITS-1:0]  peak_value;
   whpp_pkg::status_type           status;

   assign sample    = req_tdata[SAMPLE_BITS-1:0];
   // only a tlast word needs room in the result register
   assign req_tready = !rsp_valid_ff || rsp_tready || !req_tlast;
   assign req_take  = req_tvalid && req_tready;

   assign csr_ready = 1'b1;
   assign csr_ext   = {{INDEX_BITS{1'b0}}, csr_data};
   assign offset_in = (csr_valid && csr_ready) ? csr_ext[INDEX_BITS-1:0] : offset_ff;

   always_comb begin
      // candidate from two samples ago joins the best-peak compare
      confirm = pend_valid_ff[1] && (!best_valid_ff || (pend_value_ff[1] > best_value_ff));
      best_valid_in = best_valid_ff || confirm;
      best_value_in = confirm ? pend_value_ff[1] : best_value_ff;
      best_pos_in   = confirm ? pend_pos_ff[1] : best_pos_ff;

      peak_here = (pos_ff >= INDEX_BITS'(2)) && rising_ff && (sample <= prev_ff);
      pend_valid_in    = {pend_valid_ff[0], peak_here};
      pend_value_in[1] = pend_value_ff[0];
      pend_pos_in[1]   = pend_pos_ff[0];
      pend_value_in[0] = prev_ff;
      pend_pos_in[0]   = pos_ff - INDEX_BITS'(1);

      rising_in = (pos_ff != '0) && (sample > prev_ff);
      prev_in   = sample;
      pos_in    = (pos_ff == POS_MAX) ? pos_ff : pos_ff + INDEX_BITS'(1);

      index_sum = {1'b0, offset_ff} + {1'b0, best_pos_in};
      if (pos_ff < INDEX_BITS'(2)) begin
         status     = whpp_pkg::STATUS_SHORT;
         peak_index = '0;
         peak_value = '0;
      end else if (!best_valid_in) begin
         status     = whpp_pkg::STATUS_NO_PEAK;
         peak_index = '0;
         peak_value = '0;
      end else begin
         status     = whpp_pkg::STATUS_FOUND;
         peak_index = index_sum[INDEX_BITS] ? POS_MAX : index_sum[INDEX_BITS-1:0];
         peak_value = best_value_in;
      end

      rsp_data_in = RSP_BITS'({status, peak_value, peak_index});
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (req_take && req_tlast) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff     <= '0;
         rising_ff     <= 1'b0;
         pos_ff        <= '0;
         best_valid_ff <= 1'b0;
         pend_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         offset_ff    <= offset_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            if (req_tlast) begin
               rising_ff     <= 1'b0;
               pos_ff        <= '0;
               best_valid_ff <= 1'b0;
               pend_valid_ff <= '0;
            end else begin
               rising_ff     <= rising_in;
               pos_ff        <= pos_in;
               best_valid_ff <= best_valid_in;
               pend_valid_ff <= pend_valid_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         prev_ff        <= prev_in;
         best_value_ff  <= best_value_in;
         best_pos_ff    <= best_pos_in;
         pend_value_ff  <= pend_value_in;
         pend_pos_ff    <= pend_pos_in;
      end
      if (req_take && req_tlast) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // a window closes with all of its state cleared
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=>
         (pos_ff == '0) && !best_valid_ff && (pend_valid_ff == '0))
      else $error("window state not cleared after last word");

   // the second pending slot fills no earlier than position 4 (earliest peak is at 1)
   assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff[1] |-> (pos_ff >= INDEX_BITS'(4)))
      else $error("pending peak too early in window");

   // results without a peak carry zero position and value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff[RSP_USED-1 -: 2] != whpp_pkg::STATUS_FOUND)) |->
         (rsp_data_ff[INDEX_BITS+SAMPLE_BITS-1:0] == '0))
      else $error("nonzero payload on a result without a peak");

endmodule

`default_nettype wire
